// ===== hw/rtl/bmsq_pkg.sv =====
package bmsq_pkg;

  // Fixed field widths of the request and response transactions
  localparam int OP_W      = 3;
  localparam int IDX_W     = 6;
  localparam int BIT_IDX_W = 6;
  localparam int QMASK_W   = 64;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SET    = 3'd2,
    OP_UNSET  = 3'd3,
    OP_GET    = 3'd4,
    OP_QUERY  = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_BIT,
    S_QREAD,
    S_QCHECK,
    S_QDONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [IDX_W-1:0]     entry_index;
    logic [BIT_IDX_W-1:0] bit_index;
    logic [QMASK_W-1:0]   query_mask;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    result_index;
    logic                bit_value;
    logic [COUNT_W-1:0]  count_value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } rsp_t;

endpackage

// ===== hw/rtl/bitmask_table_superset_query_unit.sv =====
// Bitmask table with superset query.
//
// Request channel (req_valid / req_stall / req_data) carries one operation:
// add, remove, set bit, unset bit, get bit, query or clear. Response channel
// (rsp_valid / rsp_stall / rsp_data) returns one transaction per defined operation,
// or for a query one per matching entry in ascending index order, with last
// set on the final one. A transaction moves when valid is high and stall low.
//
// The block handles one request at a time and raises req_stall until it is
// done. Add, clear and range errors respond from the execute state; set,
// unset, get and remove with a move pass a further state, since the table is a
// single-port-read memory with a registered read. A query walks the entries
// through one shared mask compare, a read and a check state per stored entry,
// then flushes the final match from a done state. Each match is held until a
// later match or the scan's end so the last flag can be set on the true last.
//
// rsp_data sits in an output register; while the receiver stalls, the block
// holds it and stops at the next point where it must respond.
// Reset clears the entry count and the handshake state; table contents are
// left as they are and are never read before being written.
module bitmask_table_superset_query_unit
  import bmsq_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int MASK_BITS   = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int BW = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;
  localparam logic [QMASK_W-1:0] WIDTH_MASK =
    (MASK_BITS >= QMASK_W) ? {QMASK_W{1'b1}} :
                             ((QMASK_W'(1) << MASK_BITS) - QMASK_W'(1));

  // Table storage, one write port and one registered read port
  logic [MASK_BITS-1:0] mem [MAX_ENTRIES];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [MASK_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [MASK_BITS-1:0] rd_data;

  // Sequencer state
  state_t        state, state_next;
  req_t          req;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] scan_idx, scan_idx_next;
  logic [AW-1:0] pend_idx, pend_idx_next;
  logic          has_pend, has_pend_next;
  logic          rsp_valid_next;
  rsp_t          rsp_data_next;

  // Decoded request fields
  logic [AW-1:0]        ei_a;
  logic [BW-1:0]        bi_a;
  logic [CW-1:0]        count_dec;
  logic [MASK_BITS-1:0] bit_sel;
  logic [MASK_BITS-1:0] qm_w;
  logic                 ei_ok;
  logic                 bi_ok;
  logic                 qm_ok;
  logic                 match;
  logic                 out_free;
  logic                 emit;
  rsp_t                 emit_rec;
  logic                 advance;

  assign ei_a      = req.entry_index[AW-1:0];
  assign bi_a      = req.bit_index[BW-1:0];
  assign count_dec = count - CW'(1);
  assign bit_sel   = MASK_BITS'(1) << bi_a;
  assign qm_w      = req.query_mask[MASK_BITS-1:0];
  assign ei_ok     = {1'b0, req.entry_index} < COUNT_W'(count);
  assign bi_ok     = {1'b0, req.bit_index} < COUNT_W'(MASK_BITS);
  // Mask bits beyond the entry width can never be matched
  assign qm_ok     = (req.query_mask & ~WIDTH_MASK) == '0;
  // The shared compare: entry covers every bit of the query mask
  assign match     = (rd_data & qm_w) == qm_w;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      has_pend  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      has_pend  <= has_pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req <= req_data;
    end
    scan_idx <= scan_idx_next;
    pend_idx <= pend_idx_next;
    rsp_data <= rsp_data_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_idx_next  = scan_idx;
    pend_idx_next  = pend_idx;
    has_pend_next  = has_pend;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_data_next  = rsp_data;
    mem_we         = 1'b0;
    mem_waddr      = ei_a;
    mem_wdata      = rd_data;
    mem_re         = 1'b0;
    mem_raddr      = ei_a;
    emit           = 1'b0;
    emit_rec       = '0;
    emit_rec.last  = 1'b1;
    advance        = 1'b1;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        // Hold the whole decision until the output register can take a reply
        if (out_free) begin
          state_next = S_IDLE;
          case (req.op)
            OP_ADD: begin
              emit = 1'b1;
              if (count == CW'(MAX_ENTRIES)) begin
                emit_rec.status = ST_FULL;
              end else begin
                mem_we                = 1'b1;
                mem_waddr             = count[AW-1:0];
                mem_wdata             = '0;
                emit_rec.result_index = IDX_W'(count);
                emit_rec.status       = ST_OK;
                count_next            = count + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (!ei_ok) begin
                emit            = 1'b1;
                emit_rec.status = ST_RANGE;
              end else begin
                count_next = count_dec;
                if (count_dec == '0 || {1'b0, req.entry_index} == COUNT_W'(count_dec)) begin
                  emit            = 1'b1;
                  emit_rec.status = ST_OK;
                end else begin
                  // Fetch the last entry to fill the freed slot
                  mem_re     = 1'b1;
                  mem_raddr  = count_dec[AW-1:0];
                  state_next = S_MOVE;
                end
              end
            end
            OP_SET, OP_UNSET, OP_GET: begin
              if (!ei_ok || !bi_ok) begin
                emit            = 1'b1;
                emit_rec.status = ST_RANGE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = ei_a;
                state_next = S_BIT;
              end
            end
            OP_QUERY: begin
              if (!qm_ok || count == '0) begin
                emit            = 1'b1;
                emit_rec.status = ST_NOMATCH;
              end else begin
                scan_idx_next = '0;
                has_pend_next = 1'b0;
                state_next    = S_QREAD;
              end
            end
            OP_CLEAR: begin
              count_next      = '0;
              emit            = 1'b1;
              emit_rec.status = ST_OK;
            end
            default: begin
              // Unused op code: drop silently
            end
          endcase
        end
      end

      S_MOVE: begin
        if (out_free) begin
          mem_we               = 1'b1;
          mem_waddr            = ei_a;
          mem_wdata            = rd_data;
          emit                 = 1'b1;
          emit_rec.status      = ST_OK;
          emit_rec.count_value = COUNT_W'(count);
          state_next           = S_IDLE;
        end
      end

      S_BIT: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_rec.status = ST_OK;
          state_next      = S_IDLE;
          case (req.op)
            OP_SET: begin
              mem_we    = 1'b1;
              mem_wdata = rd_data | bit_sel;
            end
            OP_UNSET: begin
              mem_we    = 1'b1;
              mem_wdata = rd_data & ~bit_sel;
            end
            default: begin
              emit_rec.bit_value = rd_data[bi_a];
            end
          endcase
        end
      end

      S_QREAD: begin
        mem_re     = 1'b1;
        mem_raddr  = scan_idx;
        state_next = S_QCHECK;
      end

      S_QCHECK: begin
        if (match) begin
          if (has_pend) begin
            // A later match exists, so the held one is not the last
            if (out_free) begin
              emit                  = 1'b1;
              emit_rec.result_index = IDX_W'(pend_idx);
              emit_rec.status       = ST_OK;
              emit_rec.last         = 1'b0;
              pend_idx_next         = scan_idx;
            end else begin
              advance = 1'b0;
            end
          end else begin
            pend_idx_next = scan_idx;
            has_pend_next = 1'b1;
          end
        end
        if (advance) begin
          if ((CW'(scan_idx) + CW'(1)) == count) begin
            state_next = S_QDONE;
          end else begin
            scan_idx_next = scan_idx + AW'(1);
            state_next    = S_QREAD;
          end
        end
      end

      S_QDONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (has_pend) begin
            emit_rec.result_index = IDX_W'(pend_idx);
            emit_rec.status       = ST_OK;
          end else begin
            emit_rec.status = ST_NOMATCH;
          end
          has_pend_next = 1'b0;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      rsp_valid_next = 1'b1;
      rsp_data_next  = emit_rec;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_pend_in_query: assert property (@(posedge clk) disable iff (rst)
    has_pend |-> (state == S_QREAD || state == S_QCHECK || state == S_QDONE))
    else $error("held match outside a query scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_QCHECK |-> (CW'(scan_idx) < count))
    else $error("scan index beyond stored entries");

  a_nonlast_is_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.last |-> rsp_data.status == ST_OK)
    else $error("non-final response without ok status");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_EXEC)
    else $error("request taken without entering execute");

endmodule

// ===== test/tb_bitmask_table_superset_query_unit.sv =====
module tb_bitmask_table_superset_query_unit;
  import bmsq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = 64;
  localparam int MASK_W    = 64;

  // Op code 7 is left undefined by the block: it must be swallowed without a response.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int RAND_ITEMS      = 500;
  localparam int BURST_ITEMS     = 60;
  localparam int HOLD_OFF_CYCLES = 400;
  // Quiet time at the end of the run, longer than a full-table query scan takes.
  localparam int DRAIN_CYCLES    = 160;
  // Slowest legal run: ~600 transactions, each with the longest sender gap, a full query
  // scan and 64 responses that each sit out the longest stall, plus the hold-offs.
  // LIMIT allows a bit more than twice that.
  localparam int LIMIT           = 5_000_000;

  localparam logic [QMASK_W-1:0] ALL_ONES       = '1;
  localparam logic [QMASK_W-1:0] TOP_BIT        = 64'h8000_0000_0000_0000;
  localparam logic [QMASK_W-1:0] TOP_AND_BOTTOM = 64'h8000_0000_0000_0001;

  // Responses that can be read straight off the spec.
  localparam rsp_t OK_DONE   = '{6'd0, 1'b0, 7'd0, ST_OK, 1'b1};
  localparam rsp_t RANGE_ERR = '{6'd0, 1'b0, 7'd0, ST_RANGE, 1'b1};
  localparam rsp_t NO_MATCH  = '{6'd0, 1'b0, 7'd0, ST_NOMATCH, 1'b1};
  localparam rsp_t PREDICTED = '0;

  // One row of the directed sequence. When fixed is set, want replaces the predicted
  // response; otherwise the predictor alone decides what comes back.
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [IDX_W-1:0]     ei;
    logic [BIT_IDX_W-1:0] bi;
    logic [QMASK_W-1:0]   qm;
    logic                 fixed;
    rsp_t                 want;
  } vec_t;

  localparam int N_DIRECTED = 28;
  localparam vec_t DIRECTED [N_DIRECTED] = '{
    // empty table: query, remove, get and set all fail
    '{OP_QUERY,  6'd0,  6'd0,  64'd0,          1'b1, NO_MATCH},
    '{OP_REMOVE, 6'd0,  6'd0,  64'd0,          1'b1, RANGE_ERR},
    '{OP_GET,    6'd63, 6'd63, ALL_ONES,       1'b1, RANGE_ERR},
    '{OP_SET,    6'd0,  6'd0,  64'd0,          1'b1, RANGE_ERR},
    // build three entries
    '{OP_ADD,    6'd0,  6'd0,  64'd0,          1'b1, '{6'd0, 1'b0, 7'd0, ST_OK, 1'b1}},
    '{OP_ADD,    6'd63, 6'd63, ALL_ONES,       1'b1, '{6'd1, 1'b0, 7'd0, ST_OK, 1'b1}},
    '{OP_ADD,    6'd0,  6'd0,  64'd0,          1'b1, '{6'd2, 1'b0, 7'd0, ST_OK, 1'b1}},
    '{OP_SET,    6'd0,  6'd63, 64'd0,          1'b1, OK_DONE},
    '{OP_SET,    6'd0,  6'd0,  64'd0,          1'b1, OK_DONE},
    '{OP_SET,    6'd1,  6'd0,  64'd0,          1'b1, OK_DONE},
    '{OP_SET,    6'd2,  6'd63, 64'd0,          1'b0, PREDICTED},
    '{OP_GET,    6'd0,  6'd63, 64'd0,          1'b1, '{6'd0, 1'b1, 7'd0, ST_OK, 1'b1}},
    '{OP_GET,    6'd1,  6'd63, 64'd0,          1'b1, OK_DONE},
    // empty mask hits everything, a full mask hits nothing
    '{OP_QUERY,  6'd0,  6'd0,  64'd0,          1'b0, PREDICTED},
    '{OP_QUERY,  6'd0,  6'd0,  ALL_ONES,       1'b0, PREDICTED},
    '{OP_QUERY,  6'd0,  6'd0,  TOP_AND_BOTTOM, 1'b0, PREDICTED},
    '{OP_QUERY,  6'd0,  6'd0,  TOP_BIT,        1'b0, PREDICTED},
    '{OP_UNSET,  6'd0,  6'd63, 64'd0,          1'b1, OK_DONE},
    '{OP_GET,    6'd2,  6'd63, 64'd0,          1'b0, PREDICTED},
    '{OP_SET,    6'd3,  6'd5,  64'd0,          1'b1, RANGE_ERR},
    // undefined op: no response at all
    '{OP_UNUSED, 6'd63, 6'd63, ALL_ONES,       1'b0, PREDICTED},
    // remove with a move, remove of the last slot, remove down to empty
    '{OP_REMOVE, 6'd0,  6'd0,  64'd0,          1'b0, PREDICTED},
    '{OP_REMOVE, 6'd1,  6'd0,  64'd0,          1'b1, OK_DONE},
    '{OP_QUERY,  6'd0,  6'd0,  TOP_BIT,        1'b0, PREDICTED},
    '{OP_REMOVE, 6'd0,  6'd0,  64'd0,          1'b1, OK_DONE},
    '{OP_ADD,    6'd0,  6'd0,  64'd0,          1'b1, '{6'd0, 1'b0, 7'd0, ST_OK, 1'b1}},
    '{OP_CLEAR,  6'd0,  6'd0,  64'd0,          1'b1, OK_DONE},
    '{OP_GET,    6'd0,  6'd0,  64'd0,          1'b1, RANGE_ERR}
  };

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  // Shadow copy of the table, updated as each request transaction is taken.
  logic [QMASK_W-1:0] entry_mask [TBL_DEPTH];
  logic [COUNT_W-1:0] entry_cnt = '0;
  rsp_t               expected_rsp_q [$];

  int errors       = 0;
  int items_done   = 0;
  int hold_off_cnt = 0;
  bit burst        = 1'b0;
  bit send_calm    = 1'b0;

  bitmask_table_superset_query_unit #(
    .MAX_ENTRIES(TBL_DEPTH),
    .MASK_BITS  (MASK_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow table and queue the responses it must produce.
  function automatic void apply_op(req_t r);
    rsp_t o;
    rsp_t held;
    bit   have;
    int   i;
    o      = '0;
    o.last = 1'b1;
    held   = '0;
    have   = 1'b0;
    case (r.op)
      OP_ADD: begin
        if (entry_cnt >= COUNT_W'(TBL_DEPTH)) begin
          o.status = ST_FULL;
        end else begin
          entry_mask[entry_cnt[IDX_W-1:0]] = '0;
          o.result_index = entry_cnt[IDX_W-1:0];
          entry_cnt = entry_cnt + COUNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if ({1'b0, r.entry_index} >= entry_cnt) begin
          o.status = ST_RANGE;
        end else begin
          entry_cnt = entry_cnt - COUNT_W'(1);
          // Fill the hole with the last entry unless the hole was the last slot.
          if (entry_cnt != '0 && entry_cnt != {1'b0, r.entry_index}) begin
            entry_mask[r.entry_index] = entry_mask[entry_cnt[IDX_W-1:0]];
            o.count_value = entry_cnt;
          end
        end
      end
      OP_SET, OP_UNSET, OP_GET: begin
        if ({1'b0, r.entry_index} >= entry_cnt || int'(r.bit_index) >= MASK_W) begin
          o.status = ST_RANGE;
        end else if (r.op == OP_SET) begin
          entry_mask[r.entry_index][r.bit_index] = 1'b1;
        end else if (r.op == OP_UNSET) begin
          entry_mask[r.entry_index][r.bit_index] = 1'b0;
        end else begin
          o.bit_value = entry_mask[r.entry_index][r.bit_index];
        end
      end
      OP_QUERY: begin
        // Mask bits above the entry width can never be matched.
        if ((r.query_mask >> MASK_W) == '0) begin
          for (i = 0; i < int'(entry_cnt); i++) begin
            if ((entry_mask[i[IDX_W-1:0]] & r.query_mask) == r.query_mask) begin
              if (have) expected_rsp_q = {expected_rsp_q, held};
              held = '0;
              held.result_index = i[IDX_W-1:0];
              held.status = ST_OK;
              have = 1'b1;
            end
          end
        end
        if (have) begin
          held.last = 1'b1;
          o = held;
        end else begin
          o.status = ST_NOMATCH;
        end
      end
      OP_CLEAR: begin
        entry_cnt = '0;
      end
      default: begin
        return;
      end
    endcase
    expected_rsp_q = {expected_rsp_q, o};
  endfunction

  function automatic req_t mk_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] ei,
                                  logic [BIT_IDX_W-1:0] bi, logic [QMASK_W-1:0] qm);
    req_t r;
    r.op          = op;
    r.entry_index = ei;
    r.bit_index   = bi;
    r.query_mask  = qm;
    return r;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random request. In fill mode only grow the table and scatter bits into it;
  // otherwise mix every op, aiming most indexes at live entries and most query
  // masks at subsets of stored entries so that queries actually hit.
  function automatic req_t rand_req(bit fill);
    req_t        r;
    int unsigned pick;
    r = mk_req(OP_UNUSED, IDX_W'($urandom_range(0, 63)), BIT_IDX_W'($urandom_range(0, 63)),
               {$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (fill)           r.op = (pick < 60) ? OP_ADD : OP_SET;
    else if (pick < 18) r.op = OP_ADD;
    else if (pick < 28) r.op = OP_REMOVE;
    else if (pick < 46) r.op = OP_SET;
    else if (pick < 54) r.op = OP_UNSET;
    else if (pick < 68) r.op = OP_GET;
    else if (pick < 92) r.op = OP_QUERY;
    else if (pick < 95) r.op = OP_CLEAR;
    if (entry_cnt != 0 && $urandom_range(0, 9) != 0)
      r.entry_index = IDX_W'($urandom_range(0, int'(entry_cnt) - 1));
    if (r.op == OP_QUERY) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        r.query_mask = '0;
      end else if (pick > 1 && entry_cnt != 0) begin
        r.query_mask = entry_mask[IDX_W'($urandom_range(0, int'(entry_cnt) - 1))]
                       & {$urandom, $urandom};
        if (pick > 5) r.query_mask &= {$urandom, $urandom};
      end
    end
    return r;
  endfunction

  // Offer one request transaction, hold it until it is taken, then predict it
  // and maybe idle. Valid stays high into the next call when no gap is drawn.
  task automatic send(req_t r, bit fixed, rsp_t want);
    int gap;
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    apply_op(r);
    if (fixed) begin
      void'(expected_rsp_q.pop_back());
      expected_rsp_q = {expected_rsp_q, want};
    end
    if (r.op != OP_UNUSED) items_done++;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = (burst || send_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every queued response has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed rows.
    foreach (DIRECTED[i])
      send(mk_req(DIRECTED[i].op, DIRECTED[i].ei, DIRECTED[i].bi, DIRECTED[i].qm),
           DIRECTED[i].fixed, DIRECTED[i].want);
    wait_drained();

    // Fill the table with random content, overflow it once, then query all 64 entries.
    items_done = 0;
    while (entry_cnt < COUNT_W'(TBL_DEPTH)) send(rand_req(1'b1), 1'b0, PREDICTED);
    send(mk_req(OP_ADD, 6'd63, 6'd63, ALL_ONES), 1'b0, PREDICTED);
    send(mk_req(OP_QUERY, 6'd0, 6'd0, '0), 1'b0, PREDICTED);

    // Pause the sender until every response is back.
    wait_drained();

    // Ask the receiver for a long hold-off and keep the request side busy so the
    // block backs up and stalls its input.
    hold_off_cnt <= hold_off_cnt + 1;
    burst = 1'b1;
    repeat (BURST_ITEMS) send(rand_req(1'b0), 1'b0, PREDICTED);
    burst = 1'b0;

    while (items_done < RAND_ITEMS / 2) send(rand_req(1'b0), 1'b0, PREDICTED);
    wait_drained();
    while (items_done < RAND_ITEMS) send(rand_req(1'b0), 1'b0, PREDICTED);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_rsp_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Response side: check each accepted transaction, then decide the next stall.
  initial begin
    int   stall_left;
    int   seen_holds;
    bit   calm;
    rsp_t want;
    stall_left = 0;
    seen_holds = 0;
    calm       = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response transaction: %p", rsp_data);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_data.result_index !== want.result_index) begin
            $error("result_index: expected %0d, got %0d", want.result_index,
                   rsp_data.result_index);
            errors++;
          end
          if (rsp_data.bit_value !== want.bit_value) begin
            $error("bit_value: expected %0d, got %0d", want.bit_value, rsp_data.bit_value);
            errors++;
          end
          if (rsp_data.count_value !== want.count_value) begin
            $error("count_value: expected %0d, got %0d", want.count_value,
                   rsp_data.count_value);
            errors++;
          end
          if (rsp_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_data.status);
            errors++;
          end
          if (rsp_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_data.last);
            errors++;
          end
        end
      end
      // A new hold-off request starts a long stall counted here.
      if (hold_off_cnt != seen_holds) begin
        seen_holds = hold_off_cnt;
        stall_left = HOLD_OFF_CYCLES;
      end
      if ($urandom_range(0, 149) == 0) calm = !calm;
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else if (calm || $urandom_range(0, 9) < 7) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b1;
        stall_left = idle_len() - 1;
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
